// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled while reset is held
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, disabled while reset is held
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/bchdec_pkg.sv =====
// ----------------------------------------------------------------------------
// bchdec_pkg
// shared constants and types of the double error correcting bch decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bchdec_pkg;

  localparam int DEF_FIELD_BITS  = 5;
  localparam int DEF_CODE_LENGTH = 31;

  // field polynomial register
  localparam int                POLY_W     = 5;
  localparam logic [POLY_W-1:0] POLY_RESET = 5'd5;

  // word accept edge to the edge that takes its result, in clock edges
  localparam int PIPE_LATENCY = 9;

  // per-word decode status carried down the pipeline
  typedef struct packed {
    logic valid;
    logic any_nz;
    logic s1_nz;
    logic s2_nz;
    logic s3_nz;
    logic single;
    logic aux_nz;
  } bchdec_flags_t;

endpackage

`default_nettype wire

// ===== design/bchdec_tables.sv =====
// ----------------------------------------------------------------------------
// bchdec_tables
// field polynomial register and antilog/log table builder sweep
// ----------------------------------------------------------------------------
`default_nettype none

module bchdec_tables import bchdec_pkg::*; #(
  parameter int FIELD_BITS  = DEF_FIELD_BITS,
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [POLY_W-1:0]                cfg_field_poly,
  output logic                                  ready,
  output logic [FIELD_BITS-1:0]                 exp_tbl [CODE_LENGTH],
  output logic                                  log_we,
  output logic [FIELD_BITS-1:0]                 log_waddr,
  output logic [$clog2(CODE_LENGTH)-1:0]        log_wdata,
  output logic                                  exp_we,
  output logic [$clog2(CODE_LENGTH)-1:0]        exp_waddr,
  output logic [FIELD_BITS-1:0]                 exp_wdata
);

  localparam int M  = FIELD_BITS;
  localparam int N  = CODE_LENGTH;
  localparam int NW = $clog2(CODE_LENGTH);
  localparam int FS = 1 << FIELD_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_FILL  = 3'b010,
    ST_READY = 3'b100
  } tbl_state_t;

  tbl_state_t      state_r, state_nxt;
  logic [M-1:0]    cnt_r, cnt_nxt;
  logic [M-1:0]    lfsr_r, lfsr_nxt, lfsr_step;
  logic [POLY_W-1:0] poly_r;
  logic [M-1:0]    poly_m;
  logic [M-1:0]    exp_r [N];

  // bits of the register above the field width are ignored
  generate
    if (FIELD_BITS <= POLY_W) begin : g_poly_cut
      assign poly_m = poly_r[M-1:0];
    end else begin : g_poly_ext
      assign poly_m = {{(M-POLY_W){1'b0}}, poly_r};
    end
  endgenerate

  assign lfsr_step = {lfsr_r[M-2:0], 1'b0} ^ (lfsr_r[M-1] ? poly_m : '0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lfsr_nxt  = lfsr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + M'(1);
        if (cnt_r == M'(FS - 1)) begin
          state_nxt = ST_FILL;
          cnt_nxt   = '0;
        end
      end
      ST_FILL: begin
        lfsr_nxt = lfsr_step;
        cnt_nxt  = cnt_r + M'(1);
        if (cnt_r == M'(N - 1)) begin
          state_nxt = ST_READY;
          cnt_nxt   = '0;
        end
      end
      ST_READY: begin
        state_nxt = ST_READY;
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
    // a new polynomial restarts the whole build
    if (cfg_we) begin
      state_nxt = ST_CLEAR;
      cnt_nxt   = '0;
      lfsr_nxt  = M'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      lfsr_r  <= M'(1);
      poly_r  <= POLY_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lfsr_r  <= lfsr_nxt;
      if (cfg_we) begin
        poly_r <= cfg_field_poly;
      end
    end
  end

  // clear pass writes zero logs, fill pass writes power i at log[alpha^i]
  assign log_we    = (state_r == ST_CLEAR) || (state_r == ST_FILL);
  assign log_waddr = (state_r == ST_CLEAR) ? cnt_r : lfsr_r;
  assign log_wdata = (state_r == ST_CLEAR) ? '0 : cnt_r[NW-1:0];
  assign exp_we    = (state_r == ST_FILL);
  assign exp_waddr = cnt_r[NW-1:0];
  assign exp_wdata = lfsr_r;

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_r[exp_waddr] <= lfsr_r;
    end
  end

  assign exp_tbl = exp_r;
  assign ready   = (state_r == ST_READY);

endmodule

`default_nettype wire

// ===== design/bchdec_syndrome.sv =====
// ----------------------------------------------------------------------------
// bchdec_syndrome
// input register and syndrome stage, s1..s4 as xor trees over the antilog table
// ----------------------------------------------------------------------------
`default_nettype none

module bchdec_syndrome import bchdec_pkg::*; #(
  parameter int FIELD_BITS  = DEF_FIELD_BITS,
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_fire,
  input  wire logic [CODE_LENGTH-1:0] in_word,
  input  wire logic [FIELD_BITS-1:0]  exp_tbl [CODE_LENGTH],
  output logic                        syn_valid,
  output logic [CODE_LENGTH-1:0]      syn_word,
  output logic [FIELD_BITS-1:0]       syn [4]
);

  localparam int M = FIELD_BITS;
  localparam int N = CODE_LENGTH;

  logic         v0_r, v1_r;
  logic [N-1:0] w0_r, w1_r;
  logic [N-1:0] terms [4][M];
  logic [M-1:0] syn_nxt [4];
  logic [M-1:0] syn_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_fire;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= in_word;
    w1_r <= w0_r;
    syn_r <= syn_nxt;
  end

  // syndrome k: xor of alpha^(k*j) over the set bits j
  genvar k, b, j;
  generate
    for (k = 0; k < 4; k++) begin : g_pow
      for (b = 0; b < M; b++) begin : g_bit
        for (j = 0; j < N; j++) begin : g_pos
          localparam int IDX = ((k + 1) * j) % N;
          assign terms[k][b][j] = w0_r[j] & exp_tbl[IDX][b];
        end
        assign syn_nxt[k][b] = ^terms[k][b];
      end
    end
  endgenerate

  assign syn_valid = v1_r;
  assign syn_word  = w1_r;
  assign syn       = syn_r;

endmodule

`default_nettype wire

// ===== design/bchdec_locator.sv =====
// ----------------------------------------------------------------------------
// bchdec_locator
// log lookups, single error test and quadratic locator setup for the search
// ----------------------------------------------------------------------------
`default_nettype none

module bchdec_locator import bchdec_pkg::*; #(
  parameter int FIELD_BITS  = DEF_FIELD_BITS,
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           syn_valid,
  input  wire logic [CODE_LENGTH-1:0]         syn_word,
  input  wire logic [FIELD_BITS-1:0]          syn [4],
  input  wire logic                           log_we,
  input  wire logic [FIELD_BITS-1:0]          log_waddr,
  input  wire logic [$clog2(CODE_LENGTH)-1:0] log_wdata,
  input  wire logic                           exp_we,
  input  wire logic [$clog2(CODE_LENGTH)-1:0] exp_waddr,
  input  wire logic [FIELD_BITS-1:0]          exp_wdata,
  output bchdec_flags_t                       loc_flags,
  output logic [CODE_LENGTH-1:0]              loc_word,
  output logic [$clog2(CODE_LENGTH)-1:0]      loc_l1,
  output logic [$clog2(CODE_LENGTH)-1:0]      loc_a,
  output logic [$clog2(CODE_LENGTH)-1:0]      loc_h
);

  localparam int M  = FIELD_BITS;
  localparam int N  = CODE_LENGTH;
  localparam int NW = $clog2(CODE_LENGTH);
  localparam int FS = 1 << FIELD_BITS;
  localparam logic [NW:0] NX = (NW + 1)'(CODE_LENGTH);

  // one copy per read site: s1, s2, s3, aux
  logic [NW-1:0] log_mem [4][FS];
  // one copy per read site: 3*log(s1), log(s3)
  logic [M-1:0]  exp_mem [2][N];

  bchdec_flags_t f2_r, f3_r, f4_r, f5_r;
  bchdec_flags_t f2_nxt, f3_nxt, f4_nxt;
  logic [N-1:0]  w2_r, w3_r, w4_r, w5_r;
  logic [NW-1:0] l1_r, ls2_r, ls3_r;
  logic [NW-1:0] l1_3_r, ls2_3_r, l1_4_r, ls2_4_r, l1_5_r;
  logic [M-1:0]  ec3_r, els3_r;
  logic [NW-1:0] la_r;
  logic [NW-1:0] a_r, h_r;

  logic [NW:0]   t2, t2m, t3;
  logic [NW-1:0] c3;
  logic [M-1:0]  aux;
  logic [NW:0]   d1, d2, b2, b2m, hsum;
  logic [NW-1:0] a_nxt, h_nxt;

  always_ff @(posedge clk) begin
    if (log_we) begin
      for (int c = 0; c < 4; c++) begin
        log_mem[c][log_waddr] <= log_wdata;
      end
    end
    if (exp_we) begin
      for (int c = 0; c < 2; c++) begin
        exp_mem[c][exp_waddr] <= exp_wdata;
      end
    end
    l1_r   <= log_mem[0][syn[0]];
    ls2_r  <= log_mem[1][syn[1]];
    ls3_r  <= log_mem[2][syn[2]];
    ec3_r  <= exp_mem[0][c3];
    els3_r <= exp_mem[1][ls3_r];
    la_r   <= log_mem[3][aux];
  end

  // stage 2 status
  always_comb begin
    f2_nxt        = '0;
    f2_nxt.valid  = syn_valid;
    f2_nxt.any_nz = |(syn[0] | syn[1] | syn[2] | syn[3]);
    f2_nxt.s1_nz  = |syn[0];
    f2_nxt.s2_nz  = |syn[1];
    f2_nxt.s3_nz  = |syn[2];
  end

  // 3*log(s1) mod n by two compare-subtracts
  assign t2  = {l1_r, 1'b0};
  assign t2m = (t2 >= NX) ? t2 - NX : t2;
  assign t3  = t2m + {1'b0, l1_r};
  assign c3  = (t3 >= NX) ? NW'(t3 - NX) : NW'(t3);

  always_comb begin
    f3_nxt        = f2_r;
    f3_nxt.single = f2_r.s3_nz && (ls3_r == c3);
  end

  // a = s1^3 + s3
  assign aux = ec3_r ^ (f3_r.s3_nz ? els3_r : '0);

  always_comb begin
    f4_nxt        = f3_r;
    f4_nxt.aux_nz = |aux;
  end

  // search start points: r1 = log(s2) - log(a), r2 = log(s1) - log(a)
  assign d1 = ({1'b0, ls2_4_r} >= {1'b0, la_r}) ?
              {1'b0, ls2_4_r} - {1'b0, la_r} : {1'b0, ls2_4_r} + NX - {1'b0, la_r};
  assign d2 = ({1'b0, l1_4_r} >= {1'b0, la_r}) ?
              {1'b0, l1_4_r} - {1'b0, la_r} : {1'b0, l1_4_r} + NX - {1'b0, la_r};
  assign a_nxt = (d1 == NX - (NW + 1)'(1)) ? '0 : NW'(d1 + (NW + 1)'(1));
  assign b2    = d2 + (NW + 1)'(2);
  assign b2m   = (b2 >= NX) ? b2 - NX : b2;
  // half of the even-step start, so the second term is a plain rotation
  assign hsum  = b2m[0] ? b2m + NX : b2m;
  assign h_nxt = NW'(hsum >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_r <= '0;
      f3_r <= '0;
      f4_r <= '0;
      f5_r <= '0;
    end else begin
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
      f4_r <= f4_nxt;
      f5_r <= f4_r;
    end
  end

  always_ff @(posedge clk) begin
    w2_r    <= syn_word;
    w3_r    <= w2_r;
    w4_r    <= w3_r;
    w5_r    <= w4_r;
    l1_3_r  <= l1_r;
    ls2_3_r <= ls2_r;
    l1_4_r  <= l1_3_r;
    ls2_4_r <= ls2_3_r;
    l1_5_r  <= l1_4_r;
    a_r     <= a_nxt;
    h_r     <= h_nxt;
  end

  assign loc_flags = f5_r;
  assign loc_word  = w5_r;
  assign loc_l1    = l1_5_r;
  assign loc_a     = a_r;
  assign loc_h     = h_r;

endmodule

`default_nettype wire

// ===== design/bchdec_chien.sv =====
// ----------------------------------------------------------------------------
// bchdec_chien
// parallel root search over all positions, two-root check and correction
// ----------------------------------------------------------------------------
`default_nettype none

module bchdec_chien import bchdec_pkg::*; #(
  parameter int FIELD_BITS  = DEF_FIELD_BITS,
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bchdec_flags_t                  loc_flags,
  input  wire logic [CODE_LENGTH-1:0]         loc_word,
  input  wire logic [$clog2(CODE_LENGTH)-1:0] loc_l1,
  input  wire logic [$clog2(CODE_LENGTH)-1:0] loc_a,
  input  wire logic [$clog2(CODE_LENGTH)-1:0] loc_h,
  input  wire logic [FIELD_BITS-1:0]          exp_tbl [CODE_LENGTH],
  output logic                                out_valid,
  output logic [CODE_LENGTH-1:0]              out_word,
  output logic                                out_bad
);

  localparam int M  = FIELD_BITS;
  localparam int N  = CODE_LENGTH;
  localparam int NW = $clog2(CODE_LENGTH);

  logic [M-1:0]  ra [NW+1][N];
  logic [M-1:0]  rb [NW+1][N];
  logic [N-1:0]  pm_nxt, sm_nxt;
  logic [N-1:0]  pm6_r, sm6_r, pm7_r, sm7_r, m1_r, w6_r, w7_r;
  bchdec_flags_t f6_r, f7_r;
  logic          two, bad;
  logic [N-1:0]  flip;
  logic          valid_r, bad_r;
  logic [N-1:0]  word_r;

  // rotate the antilog table by a and its even decimation by h
  genvar s, k;
  generate
    for (k = 0; k < N; k++) begin : g_base
      localparam int DEC = (2 * k) % N;
      assign ra[0][k] = exp_tbl[k];
      assign rb[0][k] = exp_tbl[DEC];
    end
    for (s = 0; s < NW; s++) begin : g_stage
      for (k = 0; k < N; k++) begin : g_lane
        localparam int SRC = (k + (1 << s)) % N;
        assign ra[s+1][k] = loc_a[s] ? ra[s][SRC] : ra[s][k];
        assign rb[s+1][k] = loc_h[s] ? rb[s][SRC] : rb[s][k];
      end
    end
    // step k+1 lands on bit (k+1) mod n
    for (k = 0; k < N; k++) begin : g_root
      localparam int DST = (k + 1) % N;
      assign pm_nxt[DST] = ((ra[NW][k] ^ rb[NW][k]) == M'(1));
    end
  endgenerate

  assign sm_nxt = N'(1) << loc_l1;

  // exactly two roots: one set bit left after clearing the lowest
  assign two  = (|m1_r) && ((m1_r & (m1_r - N'(1))) == '0);
  assign bad  = f7_r.any_nz &&
                (!f7_r.s1_nz || (!f7_r.single && (!f7_r.aux_nz || !f7_r.s2_nz || !two)));
  assign flip = (!f7_r.any_nz || bad) ? '0 : (f7_r.single ? sm7_r : pm7_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f6_r    <= '0;
      f7_r    <= '0;
      valid_r <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      f6_r    <= loc_flags;
      f7_r    <= f6_r;
      valid_r <= f7_r.valid;
      bad_r   <= f7_r.valid && bad;
    end
  end

  always_ff @(posedge clk) begin
    pm6_r  <= pm_nxt;
    sm6_r  <= sm_nxt;
    w6_r   <= loc_word;
    pm7_r  <= pm6_r;
    sm7_r  <= sm6_r;
    m1_r   <= pm6_r & (pm6_r - N'(1));
    w7_r   <= w6_r;
    word_r <= w7_r ^ flip;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_bad   = bad_r;

endmodule

`default_nettype wire

// ===== design/bch_double_error_corrector.sv =====
// ----------------------------------------------------------------------------
// bch_double_error_corrector
// double error correcting bch decoder, (31,21) over gf(32) by default
// ----------------------------------------------------------------------------
// usage
//   a word is taken at a rising edge with start high and busy low; one word
//   may follow in every cycle while busy is low, and the pipeline holds up
//   to nine words at once; every word gives exactly one result: out_valid
//   rises with out_corrected_word and out_uncorrectable as the word leaves
//   the correction stage; the receiver cannot hold results off and the
//   pipeline never stalls
//   throughput is one word per clock while busy is low, through the
//   nine-stage pipeline (input, syndromes, log reads, cube test, locator log,
//   search start, parallel root search, two-root count, correction)
//   cfg_we writes the field polynomial; the antilog and log tables are then
//   rebuilt from it by a sweep that clears the log table and then fills both
//   tables, during which busy is high and no word is taken
//   reset clears the register to its default and starts the same sweep, so
//   busy stays high after reset until the sweep ends; write config only
//   when the pipeline is empty
// ----------------------------------------------------------------------------
`default_nettype none

module bch_double_error_corrector import bchdec_pkg::*; #(
  parameter int FIELD_BITS  = DEF_FIELD_BITS,
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // command channel
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [CODE_LENGTH-1:0] in_received_word,
  // result channel
  output logic                        out_valid,
  output logic [CODE_LENGTH-1:0]      out_corrected_word,
  output logic                        out_uncorrectable,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [POLY_W-1:0]      cfg_field_poly
);

  localparam int M  = FIELD_BITS;
  localparam int N  = CODE_LENGTH;
  localparam int NW = $clog2(CODE_LENGTH);

  logic          tbl_ready;
  logic          in_fire;
  logic [M-1:0]  exp_tbl [N];
  logic          log_we;
  logic [M-1:0]  log_waddr;
  logic [NW-1:0] log_wdata;
  logic          exp_we;
  logic [NW-1:0] exp_waddr;
  logic [M-1:0]  exp_wdata;

  logic          syn_valid;
  logic [N-1:0]  syn_word;
  logic [M-1:0]  syn [4];

  bchdec_flags_t loc_flags;
  logic [N-1:0]  loc_word;
  logic [NW-1:0] loc_l1, loc_a, loc_h;

  // no word is taken while the tables are being built or reset is held
  assign busy    = !tbl_ready || !rst_n;
  assign in_fire = start && !busy;

  // field register and table builder
  bchdec_tables #(
    .FIELD_BITS  (FIELD_BITS),
    .CODE_LENGTH (CODE_LENGTH)
  ) u_tables (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_field_poly (cfg_field_poly),
    .ready          (tbl_ready),
    .exp_tbl        (exp_tbl),
    .log_we         (log_we),
    .log_waddr      (log_waddr),
    .log_wdata      (log_wdata),
    .exp_we         (exp_we),
    .exp_waddr      (exp_waddr),
    .exp_wdata      (exp_wdata)
  );

  // stages 0-1: capture and syndromes
  bchdec_syndrome #(
    .FIELD_BITS  (FIELD_BITS),
    .CODE_LENGTH (CODE_LENGTH)
  ) u_syndrome (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (in_received_word),
    .exp_tbl   (exp_tbl),
    .syn_valid (syn_valid),
    .syn_word  (syn_word),
    .syn       (syn)
  );

  // stages 2-5: logs, single error test, locator coefficients
  bchdec_locator #(
    .FIELD_BITS  (FIELD_BITS),
    .CODE_LENGTH (CODE_LENGTH)
  ) u_locator (
    .clk       (clk),
    .rst_n     (rst_n),
    .syn_valid (syn_valid),
    .syn_word  (syn_word),
    .syn       (syn),
    .log_we    (log_we),
    .log_waddr (log_waddr),
    .log_wdata (log_wdata),
    .exp_we    (exp_we),
    .exp_waddr (exp_waddr),
    .exp_wdata (exp_wdata),
    .loc_flags (loc_flags),
    .loc_word  (loc_word),
    .loc_l1    (loc_l1),
    .loc_a     (loc_a),
    .loc_h     (loc_h)
  );

  // stages 6-8: root search, root count, correction
  bchdec_chien #(
    .FIELD_BITS  (FIELD_BITS),
    .CODE_LENGTH (CODE_LENGTH)
  ) u_chien (
    .clk       (clk),
    .rst_n     (rst_n),
    .loc_flags (loc_flags),
    .loc_word  (loc_word),
    .loc_l1    (loc_l1),
    .loc_a     (loc_a),
    .loc_h     (loc_h),
    .exp_tbl   (exp_tbl),
    .out_valid (out_valid),
    .out_word  (out_corrected_word),
    .out_bad   (out_uncorrectable)
  );

endmodule

`default_nettype wire

// ===== design/bchdec_checker.sv =====
// ----------------------------------------------------------------------------
// bchdec_checker
// port level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bchdec_checker import bchdec_pkg::*; #(
  parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   cfg_we,
  input wire logic [CODE_LENGTH-1:0] in_received_word,
  input wire logic                   out_valid,
  input wire logic [CODE_LENGTH-1:0] out_corrected_word,
  input wire logic                   out_uncorrectable
);

  `ASSERT_PROP(a_word_gives_result, clk, rst_n, (start && !busy) |-> ##PIPE_LATENCY out_valid, "accepted word gave no result")
  `ASSERT_IMP(a_result_has_word, clk, rst_n, out_valid, $past(start && !busy, PIPE_LATENCY), "result without an accepted word")
  `ASSERT_IMP(a_bad_passes_word, clk, rst_n, out_valid && out_uncorrectable, out_corrected_word == $past(in_received_word, PIPE_LATENCY), "uncorrectable word was changed")
  `ASSERT_IMP(a_at_most_two_flips, clk, rst_n, out_valid && !out_uncorrectable, $countones(out_corrected_word ^ $past(in_received_word, PIPE_LATENCY)) <= 2, "more than two bits flipped")
  `ASSERT_PROP(a_cfg_rebuilds, clk, rst_n, cfg_we |=> busy, "no table rebuild after config write")

endmodule

bind bch_double_error_corrector bchdec_checker #(
  .CODE_LENGTH (CODE_LENGTH)
) u_bchdec_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .cfg_we             (cfg_we),
  .in_received_word   (in_received_word),
  .out_valid          (out_valid),
  .out_corrected_word (out_corrected_word),
  .out_uncorrectable  (out_uncorrectable)
);

`default_nettype wire
